@@ src/arpc_pkg.sv @@
// Shared types, constants and codes for the ARP cache block.
package arpc_pkg;
    localparam int ENTRY_DEPTH  = 16;
    localparam int REQ_DEPTH    = 8;
    localparam int PKTS_PER_REQ = 4;
    localparam int EW = $clog2(ENTRY_DEPTH);
    localparam int RW = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
    localparam int PW = (PKTS_PER_REQ > 1) ? $clog2(PKTS_PER_REQ) : 1;
    localparam int PCW = $clog2(PKTS_PER_REQ + 1);
    localparam int WDEPTH = REQ_DEPTH * PKTS_PER_REQ;
    localparam int WW = $clog2(WDEPTH + 1);
    localparam int WAW = $clog2(WDEPTH);
    localparam int QDEPTH = 4;
    localparam int QW = $clog2(QDEPTH);

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_RESEND  = 2'd1;
    localparam logic [1:0] CFG_MAXSEND = 2'd2;

    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0, OP_QUEUE = 3'd1, OP_INSERT = 3'd2,
        OP_REMOVE = 3'd3, OP_TICK = 3'd4, OP_CLEAR = 3'd5
    } t_op;

    localparam logic [2:0] K_DONE    = 3'd0;
    localparam logic [2:0] K_HIT     = 3'd1;
    localparam logic [2:0] K_MISS    = 3'd2;
    localparam logic [2:0] K_ARP     = 3'd3;
    localparam logic [2:0] K_UNREACH = 3'd4;
    localparam logic [2:0] K_RELEASE = 3'd5;
    localparam logic [2:0] K_FULL    = 3'd6;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
        logic [7:0]  packet_handle;
        logic [3:0]  iface_id;
    } t_in;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] res_ip;
        logic [47:0] res_mac;
        logic [7:0]  res_packet;
        logic [3:0]  res_iface;
        logic        last;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_ESCAN, S_ERD, S_EDONE, S_QWR, S_REL, S_RELWAIT, S_EMIT,
        S_TENT, S_TREQ, S_TUNR, S_TUNRWAIT, S_TNEXT
    } t_state;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;
endpackage

@@ src/arpc_ram.sv @@
// Generic single-port-write, registered-read RAM.
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/arpc_front.sv @@
// Command front end: input queue between the command port and the engine.
module arpc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  arpc_pkg::t_in  i_item,
    input  logic           i_pop,
    output arpc_pkg::t_in  o_item,
    output arpc_pkg::t_qstat o_stat
);
    import arpc_pkg::*;
    t_in r_q [QDEPTH];
    logic [QW-1:0] r_wp, r_rp;
    logic [QW:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_item;
    end
    assign o_item = r_q[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full = (r_cnt == (QW+1)'(QDEPTH));
endmodule

@@ src/arpc_engine.sv @@
// Back end: table state and the sequencer that carries out each operation.
module arpc_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_avail,
    input  arpc_pkg::t_in  i_item,
    output logic           o_pop,
    input  logic [7:0]     i_timeout,
    input  logic [3:0]     i_resend,
    input  logic [2:0]     i_maxsend,
    output logic           o_valid,
    output arpc_pkg::t_out o_res,
    output logic           o_idle
);
    import arpc_pkg::*;
    t_state r_st, n_st;
    t_in r_it;

    logic [ENTRY_DEPTH-1:0] r_ev;
    logic [31:0] r_eip [ENTRY_DEPTH];
    logic [7:0]  r_eage [ENTRY_DEPTH];
    logic [REQ_DEPTH-1:0] r_rv;
    logic [31:0] r_rip [REQ_DEPTH];
    logic [2:0]  r_rsend [REQ_DEPTH];
    logic [3:0]  r_ridle [REQ_DEPTH];
    logic [PCW-1:0] r_rpc [REQ_DEPTH];

    logic [EW:0] r_ei;
    logic [RW:0] r_ri;
    logic [PCW-1:0] r_pi;
    logic r_hit; logic [EW-1:0] r_hidx;
    logic r_free; logic [EW-1:0] r_fidx;
    logic [2:0] r_kind;
    logic [31:0] r_rip_out;
    logic [RW-1:0] r_sel;

    // MAC store and waiting packets in RAM
    logic mac_we; logic [EW-1:0] mac_wa, mac_ra; logic [47:0] mac_rd;
    arpc_ram #(.WIDTH(48), .DEPTH(ENTRY_DEPTH)) u_mac (
        .i_clk(i_clk), .i_we(mac_we), .i_waddr(mac_wa), .i_wdata(r_it.mac_addr),
        .i_raddr(mac_ra), .o_rdata(mac_rd));
    logic w_we; logic [WAW-1:0] w_wa, w_ra; logic [11:0] w_rd;
    arpc_ram #(.WIDTH(12), .DEPTH(WDEPTH)) u_wait (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_wa),
        .i_wdata({r_it.packet_handle, r_it.iface_id}), .i_raddr(w_ra), .o_rdata(w_rd));

    // request search (REQ_DEPTH compares, narrow tree)
    logic rq_hit; logic [RW-1:0] rq_idx; logic rq_free; logic [RW-1:0] rq_fidx;
    always_comb begin
        rq_hit = 1'b0; rq_idx = '0; rq_free = 1'b0; rq_fidx = '0;
        for (int r = REQ_DEPTH - 1; r >= 0; r--) begin
            if (r_rv[r] && r_rip[r] == r_it.ip_addr) begin
                rq_hit = 1'b1; rq_idx = RW'(r);
            end
            if (!r_rv[r]) begin
                rq_free = 1'b1; rq_fidx = RW'(r);
            end
        end
    end

    // queued packet goes to the matching request, else to the lowest free one
    logic [RW-1:0] q_sel; logic [PCW-1:0] q_cnt; logic qful;
    assign q_sel = rq_hit ? rq_idx : rq_fidx;
    assign q_cnt = rq_hit ? r_rpc[rq_idx] : '0;
    assign qful = rq_hit ? (r_rpc[rq_idx] == PCW'(PKTS_PER_REQ)) : !rq_free;

    logic [EW-1:0] ei; logic [RW-1:0] ri;
    assign ei = r_ei[EW-1:0];
    assign ri = r_ri[RW-1:0];
    logic [7:0] age_inc; logic [3:0] idle_inc;
    assign age_inc = (r_eage[ei] == 8'hFF) ? 8'hFF : r_eage[ei] + 8'd1;
    assign idle_inc = (r_ridle[ri] == 4'hF) ? 4'hF : r_ridle[ri] + 4'd1;
    logic act, fail;
    assign act = (r_rsend[ri] == 3'd0) || (idle_inc >= i_resend);
    assign fail = (r_rsend[ri] >= i_maxsend);

    assign mac_ra = r_hidx;
    assign mac_wa = r_hit ? r_hidx : r_fidx;
    assign w_wa = WAW'(q_sel * PKTS_PER_REQ + q_cnt[PW-1:0]);
    assign w_ra = WAW'(r_sel * PKTS_PER_REQ + r_pi[PW-1:0]);

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_avail) begin
                unique case (i_item.op) inside
                    OP_LOOKUP, OP_INSERT: n_st = S_ESCAN;
                    OP_QUEUE: n_st = S_QWR;
                    OP_TICK: n_st = S_TENT;
                    default: n_st = S_EMIT;
                endcase
            end
            S_ESCAN: if (r_ei == (EW+1)'(ENTRY_DEPTH - 1)) n_st = S_ERD;
            S_ERD: n_st = S_EDONE;
            S_EDONE: begin
                if (r_it.op == OP_INSERT && (r_hit || r_free) && rq_hit
                    && r_rpc[rq_idx] != '0) n_st = S_REL;
                else n_st = S_EMIT;
            end
            S_QWR: n_st = S_EMIT;
            S_REL: n_st = S_RELWAIT;
            S_RELWAIT: n_st = (r_pi + 1'b1 == r_rpc[r_sel]) ? S_EMIT : S_REL;
            S_EMIT: n_st = S_IDLE;
            S_TENT: if (r_ei == (EW+1)'(ENTRY_DEPTH - 1)) n_st = S_TREQ;
            S_TREQ: begin
                if (r_rv[ri] && act && fail && r_rpc[ri] != '0)
                    n_st = S_TUNR;
                else n_st = S_TNEXT;
            end
            S_TUNR: n_st = S_TUNRWAIT;
            S_TUNRWAIT: n_st = (r_pi + 1'b1 == r_rpc[r_sel]) ? S_TNEXT : S_TUNR;
            S_TNEXT: n_st = (r_ri == (RW+1)'(REQ_DEPTH - 1)) ? S_EMIT : S_TREQ;
            default: n_st = S_IDLE;
        endcase
    end

    // outputs and strobes
    always_comb begin
        o_pop = 1'b0; o_valid = 1'b0; o_res = '0; mac_we = 1'b0; w_we = 1'b0;
        unique case (r_st) inside
            S_IDLE: o_pop = i_avail;
            S_EDONE: mac_we = (r_it.op == OP_INSERT) && (r_hit || r_free);
            S_QWR: w_we = !qful;
            S_RELWAIT, S_TUNRWAIT: begin
                o_valid = 1'b1;
                o_res.result_kind = (r_st == S_RELWAIT) ? K_RELEASE : K_UNREACH;
                o_res.res_ip = r_rip_out;
                o_res.res_packet = w_rd[11:4];
                o_res.res_iface = w_rd[3:0];
            end
            S_TREQ: if (r_rv[ri] && act && !fail) begin
                o_valid = 1'b1;
                o_res.result_kind = K_ARP;
                o_res.res_ip = r_rip[ri];
            end
            S_EMIT: begin
                o_valid = 1'b1;
                o_res.result_kind = r_kind;
                o_res.res_ip = r_it.ip_addr;
                o_res.res_mac = (r_kind == K_HIT) ? mac_rd : 48'd0;
                o_res.last = 1'b1;
            end
            default: ;
        endcase
    end
    assign o_idle = (r_st == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ev <= '0; r_rv <= '0;
        end else begin
            r_st <= n_st;
            unique case (r_st) inside
                S_IDLE: if (i_avail) begin
                    r_it <= i_item; r_ei <= '0; r_ri <= '0; r_pi <= '0;
                    r_hit <= 1'b0; r_free <= 1'b0; r_kind <= K_DONE;
                    if (i_item.op == OP_CLEAR) begin
                        r_ev <= '0; r_rv <= '0;
                    end
                end
                S_ESCAN: begin
                    if (!r_hit && r_ev[ei] && r_eip[ei] == r_it.ip_addr) begin
                        r_hit <= 1'b1; r_hidx <= ei;
                    end
                    if (!r_free && !r_ev[ei]) begin
                        r_free <= 1'b1; r_fidx <= ei;
                    end
                    r_ei <= r_ei + 1'b1;
                end
                S_EDONE: begin
                    r_sel <= rq_idx; r_pi <= '0; r_rip_out <= r_it.ip_addr;
                    if (r_it.op == OP_LOOKUP) r_kind <= r_hit ? K_HIT : K_MISS;
                    else if (r_hit || r_free) begin
                        r_ev[mac_wa] <= 1'b1; r_eip[mac_wa] <= r_it.ip_addr;
                        r_eage[mac_wa] <= 8'd0; r_kind <= K_DONE;
                    end else r_kind <= K_FULL;
                end
                S_ERD: ;
                S_QWR: begin
                    if (qful) r_kind <= K_FULL;
                    else begin
                        if (!rq_hit) begin
                            r_rv[q_sel] <= 1'b1; r_rip[q_sel] <= r_it.ip_addr;
                            r_rsend[q_sel] <= '0; r_ridle[q_sel] <= '0;
                        end
                        r_rpc[q_sel] <= q_cnt + 1'b1;
                    end
                end
                S_RELWAIT, S_TUNRWAIT: r_pi <= r_pi + 1'b1;
                S_TENT: begin
                    if (r_ev[ei]) begin
                        r_eage[ei] <= age_inc;
                        if (age_inc > i_timeout) r_ev[ei] <= 1'b0;
                    end
                    r_ei <= r_ei + 1'b1;
                end
                S_TREQ: begin
                    r_sel <= ri; r_pi <= '0; r_rip_out <= r_rip[ri];
                    if (r_rv[ri]) begin
                        r_ridle[ri] <= (act && !fail) ? 4'd0 : idle_inc;
                        if (act && fail) r_rv[ri] <= 1'b0;
                        if (act && !fail) r_rsend[ri] <= r_rsend[ri] + 3'd1;
                    end
                end
                S_TNEXT: r_ri <= r_ri + 1'b1;
                S_EMIT: begin
                    if (r_it.op == OP_REMOVE && rq_hit) r_rv[rq_idx] <= 1'b0;
                end
                default: ;
            endcase
        end
    end
endmodule

@@ src/arp_cache_with_pending_requests_unit.sv @@
// Top level of the ARP cache with pending requests.
// Lookup, insert and tick scan all 16 entries; insert then releases the packets waiting on
// its address, and tick walks every pending request. The engine works one item at a time
// while a 4-deep queue takes new items, so busy rises only when it is full. Results cannot
// be held off. Synchronous active-low reset clears valid bits, control state and queue
// pointers, and loads the configuration registers with their defaults.
module arp_cache_with_pending_requests_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  arpc_pkg::t_in   i_item,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [7:0]      i_cfg_data,
    output logic            o_strobe,
    output arpc_pkg::t_out  o_res
);
    import arpc_pkg::*;
    logic [7:0] r_timeout; logic [3:0] r_resend; logic [2:0] r_maxsend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 8'd30; r_resend <= 4'd1; r_maxsend <= 3'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_RESEND:  r_resend <= i_cfg_data[3:0];
                CFG_MAXSEND: r_maxsend <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    t_qstat qs; t_in q_item; logic pop, eidle, v; t_out res;
    assign busy = qs.full;
    arpc_front u_front (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(start && !busy),
        .i_item(i_item), .i_pop(pop), .o_item(q_item), .o_stat(qs));
    arpc_engine u_eng (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_avail(!qs.empty),
        .i_item(q_item), .o_pop(pop), .i_timeout(r_timeout), .i_resend(r_resend),
        .i_maxsend(r_maxsend), .o_valid(v), .o_res(res), .o_idle(eidle));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_strobe <= 1'b0;
        else o_strobe <= v;
        o_res <= res;
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qs.empty) else $error("pop from empty queue");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> eidle) else $error("pop while engine busy");
    a_no_busy_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !$past(start && !busy)) else $error("push while full");
endmodule
